[rtl/core/hbs_pkg.sv]
// Shared types and constants of the heightmap bilinear sampler.
package hbs_pkg;

    localparam int GRID_SIDE_DEF   = 512;
    localparam int HEIGHT_BITS_DEF = 16;

    localparam int COORD_W  = 9;
    localparam int OFFSET_W = 16;
    localparam int WRITE_W  = 16;
    localparam int OUT_W    = 32;
    localparam int FRAC_BITS = 12;

    localparam logic signed [OFFSET_W-1:0] ONE_Q12 = 16'sd4096;
    localparam logic signed [OUT_W-1:0]    OUT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0]    OUT_MIN = 32'sh8000_0000;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

    // Corner order in use_corner: 0 = (x,y), 1 = (x+1,y), 2 = (x,y+1), 3 = (x+1,y+1).
    typedef struct packed {
        logic       valid;
        logic       outside;
        logic       par_x;
        logic       par_y;
        logic [3:0] use_corner;
    } t_smp_ctl;

endpackage

[rtl/core/hbs_bank.sv]
// Single-port height memory bank with registered read data.
module hbs_bank #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/hbs_blend.sv]
// Bilinear blend pipeline: corner routing, differences, products, sum and saturation.
module hbs_blend
    import hbs_pkg::*;
#(
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_smp_ctl                   i_ctl,
    input  logic signed [OFFSET_W-1:0] i_tx,
    input  logic signed [OFFSET_W-1:0] i_ty,
    input  logic [HEIGHT_BITS-1:0]     i_bank_data [4],
    output logic                       o_take,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [OUT_W-1:0]    o_height_q12,
    output logic                       o_outside_grid
);

    localparam int DX_W  = HEIGHT_BITS + 1;
    localparam int DD_W  = HEIGHT_BITS + 2;
    localparam int TT_W  = 2 * OFFSET_W;
    localparam int PX_W  = OFFSET_W + DX_W;
    localparam int MX_W  = TT_W + DD_W;
    localparam int BS_W  = HEIGHT_BITS + FRAC_BITS + 1;
    localparam int SUM_W = MX_W + 1;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(OUT_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(OUT_MIN);

    logic                   en2, en3, en4;
    logic [HEIGHT_BITS-1:0] w_corner [4];
    logic signed [DX_W-1:0] w_dx, w_dy;
    logic signed [DD_W-1:0] w_dd;
    logic signed [TT_W-1:0] w_tt;

    // stage 2
    logic                       r_s2_valid, r_s2_outside;
    logic [HEIGHT_BITS-1:0]     r_s2_h00;
    logic signed [DX_W-1:0]     r_s2_dx, r_s2_dy;
    logic signed [DD_W-1:0]     r_s2_dd;
    logic signed [TT_W-1:0]     r_s2_tt;
    logic signed [OFFSET_W-1:0] r_s2_tx, r_s2_ty;

    // stage 3
    logic                   r_s3_valid, r_s3_outside;
    logic [HEIGHT_BITS-1:0] r_s3_h00;
    logic signed [PX_W-1:0] r_s3_px, r_s3_py;
    logic signed [MX_W-1:0] r_s3_mx;

    // output stage
    logic                    r_out_valid, r_out_outside;
    logic signed [OUT_W-1:0] r_out_height;
    logic signed [BS_W-1:0]  w_base;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [OUT_W-1:0] w_sat;

    // Advance a stage when it is empty or its successor advances.
    assign en4    = !r_out_valid || i_ready;
    assign en3    = !r_s3_valid || en4;
    assign en2    = !r_s2_valid || en3;
    assign o_take = en2;

    // Route each corner from its bank; drop corners that carry no weight.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_corner[k] = i_bank_data[{i_ctl.par_y ^ k[1], i_ctl.par_x ^ k[0]}]
                        & {HEIGHT_BITS{i_ctl.use_corner[k]}};
        end
    end

    assign w_dx = $signed({1'b0, w_corner[1]}) - $signed({1'b0, w_corner[0]});
    assign w_dy = $signed({1'b0, w_corner[2]}) - $signed({1'b0, w_corner[0]});
    assign w_dd = $signed({2'b00, w_corner[0]}) - $signed({2'b00, w_corner[1]})
                - $signed({2'b00, w_corner[2]}) + $signed({2'b00, w_corner[3]});
    assign w_tt = TT_W'(i_tx) * TT_W'(i_ty);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_outside <= i_ctl.outside;
            r_s2_h00     <= w_corner[0];
            r_s2_dx      <= w_dx;
            r_s2_dy      <= w_dy;
            r_s2_dd      <= w_dd;
            r_s2_tt      <= w_tt;
            r_s2_tx      <= i_tx;
            r_s2_ty      <= i_ty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_outside <= r_s2_outside;
            r_s3_h00     <= r_s2_h00;
            r_s3_px      <= PX_W'(r_s2_tx) * PX_W'(r_s2_dx);
            r_s3_py      <= PX_W'(r_s2_ty) * PX_W'(r_s2_dy);
            r_s3_mx      <= MX_W'(r_s2_tt) * MX_W'(r_s2_dd);
        end
    end

    // The first three terms are already exact in Q.12, so floor only the mixed term.
    assign w_base = $signed({1'b0, r_s3_h00, {FRAC_BITS{1'b0}}});
    assign w_sum  = SUM_W'(w_base) + SUM_W'(r_s3_px) + SUM_W'(r_s3_py)
                  + SUM_W'(r_s3_mx >>> FRAC_BITS);

    always_comb begin
        if (r_s3_outside) begin
            w_sat = '0;
        end else if (w_sum > SAT_HI) begin
            w_sat = OUT_MAX;
        end else if (w_sum < SAT_LO) begin
            w_sat = OUT_MIN;
        end else begin
            w_sat = w_sum[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en4) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_out_height  <= w_sat;
            r_out_outside <= r_s3_outside;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_height_q12   = r_out_height;
    assign o_outside_grid = r_out_outside;

endmodule

[rtl/core/heightmap_bilinear_sampler_top.sv]
// Top level of the heightmap bilinear sampler: request decode, banked store, blend pipeline.
//
// The sampler holds a GRID_SIDE x GRID_SIDE grid of unsigned heights and takes one request
// per clock while o_ready is high. A write request stores one cell (ignored beyond the
// grid) and returns nothing; a sample request returns the bilinear blend of the four
// corners of the cell at (cell_x, cell_y), weighted by signed Q4.12 offsets that may
// extrapolate, as a Q.12 value truncated toward minus infinity and saturated to 32 bits.
// If a corner with nonzero weight lies beyond the grid the result is zero with outside_grid
// set. The grid is split into four single-port banks by the parity of column and row, so
// the four corners of any cell sit in four different banks and are read in the one cycle
// in which the request is accepted; a write uses one bank in its cycle. Throughput is one
// request per cycle unless stalled; a sample passes through the bank read, differences and
// tx*ty, products, and sum and saturation into the output register. Reads and writes both
// happen at the acceptance edge, so a sample always sees every earlier write and needs no
// forwarding. Each stage moves whenever its successor has room, so bubbles close up and
// requests keep flowing into empty stages while a result waits at the output. Cells must be
// written before a sample weights them; the store has no reset and needs no clearing pass.
module heightmap_bilinear_sampler_top
    import hbs_pkg::*;
#(
    parameter int GRID_SIDE   = GRID_SIDE_DEF,
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_cmd,
    input  logic [COORD_W-1:0]         i_cell_x,
    input  logic [COORD_W-1:0]         i_cell_y,
    input  logic signed [OFFSET_W-1:0] i_offset_x,
    input  logic signed [OFFSET_W-1:0] i_offset_y,
    input  logic [WRITE_W-1:0]         i_write_height,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [OUT_W-1:0]    o_height_q12,
    output logic                       o_outside_grid
);

    // Each bank covers every other column and every other row.
    localparam int HALF   = (GRID_SIDE + 1) / 2;
    localparam int HALF_W = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int ADDR_W = 2 * HALF_W;

    logic                   accept, is_sample, is_write;
    logic                   s1_take;
    logic [COORD_W:0]       cx_p1, cy_p1;
    logic [HALF_W-1:0]      col_even, col_odd, row_even, row_odd;
    logic [HALF_W-1:0]      wr_col, wr_row;
    logic                   wr_in_grid;
    logic [1:0]             wr_bank;
    logic                   need_c0, need_c1, need_r0, need_r1;
    logic                   c0_out, c1_out, r0_out, r1_out;
    logic                   w_outside;
    logic [HEIGHT_BITS-1:0] wr_data;
    logic [HEIGHT_BITS-1:0] bank_data [4];

    t_smp_ctl                   r_s1_ctl, n_s1_ctl;
    logic signed [OFFSET_W-1:0] r_s1_tx, r_s1_ty;

    // Take a request whenever stage 1 is empty or hands its sample on.
    assign o_ready   = !r_s1_ctl.valid || s1_take;
    assign accept    = i_valid && o_ready;
    assign is_sample = accept && (t_cmd'(i_cmd) == CMD_SAMPLE);
    assign is_write  = accept && (t_cmd'(i_cmd) == CMD_WRITE);

    assign cx_p1 = {1'b0, i_cell_x} + 1'b1;
    assign cy_p1 = {1'b0, i_cell_y} + 1'b1;

    // Column x lands in the bank of its parity; the even bank sees the even one of x, x+1.
    assign col_even = HALF_W'(cx_p1 >> 1);
    assign col_odd  = HALF_W'(i_cell_x >> 1);
    assign row_even = HALF_W'(cy_p1 >> 1);
    assign row_odd  = HALF_W'(i_cell_y >> 1);

    assign wr_col     = HALF_W'(i_cell_x >> 1);
    assign wr_row     = HALF_W'(i_cell_y >> 1);
    assign wr_bank    = {i_cell_y[0], i_cell_x[0]};
    assign wr_in_grid = (int'(i_cell_x) < GRID_SIDE) && (int'(i_cell_y) < GRID_SIDE);
    assign wr_data    = HEIGHT_BITS'(i_write_height);

    // A corner matters only when its blend weight is nonzero.
    assign need_c0 = i_offset_x != ONE_Q12;
    assign need_c1 = i_offset_x != '0;
    assign need_r0 = i_offset_y != ONE_Q12;
    assign need_r1 = i_offset_y != '0;
    assign c0_out  = int'(i_cell_x) >= GRID_SIDE;
    assign c1_out  = int'(cx_p1) >= GRID_SIDE;
    assign r0_out  = int'(i_cell_y) >= GRID_SIDE;
    assign r1_out  = int'(cy_p1) >= GRID_SIDE;

    assign w_outside = (need_c0 && need_r0 && (c0_out || r0_out))
                    || (need_c1 && need_r0 && (c1_out || r0_out))
                    || (need_c0 && need_r1 && (c0_out || r1_out))
                    || (need_c1 && need_r1 && (c1_out || r1_out));

    generate
        for (genvar b = 0; b < 4; b++) begin : g_bank
            logic [HALF_W-1:0] rd_col, rd_row;
            logic [ADDR_W-1:0] addr;
            logic              wr_en;

            assign rd_col = b[0] ? col_odd : col_even;
            assign rd_row = b[1] ? row_odd : row_even;
            assign wr_en  = is_write && wr_in_grid && (wr_bank == 2'(b));
            assign addr   = is_sample ? {rd_row, rd_col} : {wr_row, wr_col};

            hbs_bank #(
                .ADDR_W (ADDR_W),
                .DATA_W (HEIGHT_BITS)
            ) u_bank (
                .i_clk     (i_clk),
                .i_wr_en   (wr_en),
                .i_rd_en   (is_sample),
                .i_addr    (addr),
                .i_wr_data (wr_data),
                .o_rd_data (bank_data[b])
            );
        end
    endgenerate

    // Stage 1 sits beside the bank read registers: it holds what the blend needs
    // to route and weight the corners that arrive there.
    always_comb begin
        n_s1_ctl = r_s1_ctl;
        if (accept) begin
            n_s1_ctl.valid      = (t_cmd'(i_cmd) == CMD_SAMPLE);
            n_s1_ctl.outside    = w_outside;
            n_s1_ctl.par_x      = i_cell_x[0];
            n_s1_ctl.par_y      = i_cell_y[0];
            n_s1_ctl.use_corner = {need_c1 && need_r1, need_c0 && need_r1,
                                   need_c1 && need_r0, need_c0 && need_r0};
        end else if (s1_take) begin
            n_s1_ctl.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else begin
            r_s1_ctl <= n_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_sample) begin
            r_s1_tx <= i_offset_x;
            r_s1_ty <= i_offset_y;
        end
    end

    hbs_blend #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_blend (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (r_s1_ctl),
        .i_tx           (r_s1_tx),
        .i_ty           (r_s1_ty),
        .i_bank_data    (bank_data),
        .o_take         (s1_take),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_height_q12   (o_height_q12),
        .o_outside_grid (o_outside_grid)
    );

endmodule
